FILE: rtl/ppc_pkg.sv
// Probe packet checker package: status codes, size limits, seen-map row geometry
// and the per-packet summary that travels from the word parser to the status stage.
// No dependencies.
package ppc_pkg;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
  localparam logic [2:0] ST_LEN_MISMATCH = 3'd2;
  localparam logic [2:0] ST_SEQ_RANGE    = 3'd3;
  localparam logic [2:0] ST_DUPLICATE    = 3'd4;
  localparam logic [2:0] ST_PAYLOAD      = 3'd5;

  localparam logic [11:0] MIN_BYTES = 12'd16;
  localparam logic [11:0] MAX_BYTES = 12'd1400;
  localparam logic [11:0] SAT_BYTES = 12'd2048;
  localparam logic [9:0]  POS_MAX   = 10'd1023;
  localparam logic [9:0]  POS_SAT   = 10'd512;
  localparam logic [16:0] TOTAL_MAX = 17'h1FFFF;

  localparam int unsigned ROW_BITS = 32;
  localparam int unsigned ROW_LSB  = 5;

  typedef struct packed {
    logic [2:0]  pre_status;
    logic        payload_bad;
    logic [31:0] seq;
    logic [11:0] bytes;
  } pkt_info_t;

endpackage

FILE: rtl/ppc_parse.sv
// Word parser: tracks position, declared length, header sequence and payload
// compare for the packet in flight; summarizes the packet on its last word.
// Depends on ppc_pkg.
module ppc_parse #(
  parameter int unsigned SEQ_SPACE = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [31:0]       data_word,
  input  logic              is_last,
  input  logic [2:0]        last_valid_bytes,
  output ppc_pkg::pkt_info_t info
);
  import ppc_pkg::*;

  logic [9:0]  word_position;
  logic [31:0] declared_length;
  logic [31:0] header_sequence;
  logic        payload_bad;

  logic [2:0]  vb;
  logic [31:0] mask;
  logic [31:0] word_m;
  logic [31:0] decl;
  logic [31:0] seq;
  logic        mism;
  logic [11:0] bytes;
  logic        size_bad;
  logic        len_bad;
  logic        range_bad;

  always_comb begin
    vb = (last_valid_bytes == 3'd0 || last_valid_bytes > 3'd4) ? 3'd4 : last_valid_bytes;
    case (vb)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    word_m = is_last ? (data_word & mask) : data_word;
    decl   = (word_position == 10'd0) ? word_m : declared_length;
    seq    = (word_position == 10'd1) ? word_m : header_sequence;
    mism   = (word_position >= 10'd4) && (word_m != header_sequence);
    if (word_position >= POS_SAT) begin
      bytes = SAT_BYTES;
    end else begin
      bytes = 12'({word_position[8:0], 2'b00}) + 12'(vb);
    end
    size_bad  = (bytes < MIN_BYTES) || (bytes > MAX_BYTES);
    len_bad   = decl != 32'(bytes);
    range_bad = {1'b0, seq} >= 33'(SEQ_SPACE);

    info.seq         = seq;
    info.bytes       = bytes;
    info.payload_bad = payload_bad | mism;
    if (size_bad) begin
      info.pre_status = ST_BAD_SIZE;
    end else if (len_bad) begin
      info.pre_status = ST_LEN_MISMATCH;
    end else if (range_bad) begin
      info.pre_status = ST_SEQ_RANGE;
    end else begin
      info.pre_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && is_last)) begin
      word_position   <= '0;
      declared_length <= '0;
      header_sequence <= '0;
      payload_bad     <= 1'b0;
    end else if (accept) begin
      if (word_position == 10'd0) begin
        declared_length <= data_word;
      end
      if (word_position == 10'd1) begin
        header_sequence <= data_word;
      end
      if (mism) begin
        payload_bad <= 1'b1;
      end
      if (word_position < POS_MAX) begin
        word_position <= word_position + 10'd1;
      end
    end
  end

endmodule

FILE: rtl/ppc_seen_map.sv
// Seen-sequence bitmap: synchronous memory of 32-bit rows with one read and one
// write port, write forwarding and a clearing sweep after reset. Depends on ppc_pkg.
module ppc_seen_map #(
  parameter int unsigned ROWS  = 2048,
  parameter int unsigned ROW_W = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [ROW_W-1:0]             rd_row,
  input  logic                         wr_en,
  input  logic [ROW_W-1:0]             wr_row,
  input  logic [ppc_pkg::ROW_BITS-1:0] wr_data,
  output logic [ppc_pkg::ROW_BITS-1:0] rd_data,
  output logic                         busy
);
  import ppc_pkg::*;

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] mem_q;
  logic [ROW_W-1:0]    rd_row_q;

  logic                clr_active;
  logic [ROW_W-1:0]    clr_row;

  logic                we;
  logic [ROW_W-1:0]    waddr;
  logic [ROW_BITS-1:0] wdata;

  logic                fwd_valid;
  logic [ROW_W-1:0]    fwd_row;
  logic [ROW_BITS-1:0] fwd_data;

  assign we    = clr_active | wr_en;
  assign waddr = clr_active ? clr_row : wr_row;
  assign wdata = clr_active ? '0 : wr_data;
  assign busy  = clr_active;
  assign rd_data = (fwd_valid && fwd_row == rd_row_q) ? fwd_data : mem_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_row];
      rd_row_q <= rd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_row  <= waddr;
      fwd_data <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_row    <= '0;
    end else if (clr_active) begin
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_row <= clr_row + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/probe_packet_checker_core.sv
// Probe packet checker top level: input handshake, status stage, good-packet
// total and output register. Depends on ppc_pkg, ppc_parse and ppc_seen_map.
//
// Takes one 32-bit word per cycle while in_ready is high. The last word of a packet
// reads its seen-map row from memory into the status stage, which presents one
// result through the output register; other words yield nothing. Apart from the
// seen-map clear, in_ready drops only while a finished packet waits behind a held
// result. Results of back-to-back packets sharing a seen-map row are resolved by
// forwarding the last write. After reset the seen map is cleared one 32-bit row
// per cycle, ceil(SEQ_SPACE/32) rows (2048 at the default), during which in_ready
// stays low; expected_count may be written then.
module probe_packet_checker_core #(
  parameter int unsigned SEQ_SPACE = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] expected_count,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic        is_last,
  input  logic [2:0]  last_valid_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] sequence_number,
  output logic [11:0] byte_count,
  output logic [16:0] good_count,
  output logic        all_received
);
  import ppc_pkg::*;

  localparam int unsigned ROWS  = (SEQ_SPACE + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic                accept;
  logic                last_accept;
  logic                busy;
  pkt_info_t           info;
  pkt_info_t           s1_info;
  logic                s1_valid;
  logic                s1_advance;
  logic                out_free;
  logic [ROW_BITS-1:0] row_data;
  logic [ROW_LSB-1:0]  bit_idx;
  logic [2:0]          status_next;
  logic                good;
  logic [16:0]         expected_total;
  logic [16:0]         received_total;
  logic [16:0]         received_total_next;
  logic                wr_en;
  logic [ROW_BITS-1:0] wr_data;

  assign cfg_ready   = 1'b1;
  assign out_free    = !out_valid || out_ready;
  assign s1_advance  = s1_valid && out_free;
  assign in_ready    = !busy && (!s1_valid || out_free);
  assign accept      = in_valid && in_ready;
  assign last_accept = accept && is_last;

  ppc_parse #(
    .SEQ_SPACE(SEQ_SPACE)
  ) u_parse (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .data_word        (data_word),
    .is_last          (is_last),
    .last_valid_bytes (last_valid_bytes),
    .info             (info)
  );

  ppc_seen_map #(
    .ROWS (ROWS),
    .ROW_W(ROW_W)
  ) u_map (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (last_accept),
    .rd_row (info.seq[ROW_LSB +: ROW_W]),
    .wr_en  (wr_en),
    .wr_row (s1_info.seq[ROW_LSB +: ROW_W]),
    .wr_data(wr_data),
    .rd_data(row_data),
    .busy   (busy)
  );

  always_comb begin
    bit_idx = s1_info.seq[ROW_LSB-1:0];
    if (s1_info.pre_status != ST_OK) begin
      status_next = s1_info.pre_status;
    end else if (row_data[bit_idx]) begin
      status_next = ST_DUPLICATE;
    end else if (s1_info.payload_bad) begin
      status_next = ST_PAYLOAD;
    end else begin
      status_next = ST_OK;
    end
    good    = status_next == ST_OK;
    wr_en   = s1_advance && good;
    wr_data = row_data | (ROW_BITS'(1) << bit_idx);
    if (good && received_total != TOTAL_MAX) begin
      received_total_next = received_total + 17'd1;
    end else begin
      received_total_next = received_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_total <= 17'h10000;
    end else if (cfg_valid && cfg_ready) begin
      expected_total <= expected_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (last_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_accept) begin
      s1_info <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      received_total <= '0;
      out_valid      <= 1'b0;
    end else if (s1_advance) begin
      received_total <= received_total_next;
      out_valid      <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      status          <= status_next;
      sequence_number <= s1_info.seq;
      byte_count      <= s1_info.bytes;
      good_count      <= received_total_next;
      all_received    <= received_total_next == expected_total;
    end
  end

endmodule

FILE: rtl/ppc_checker.sv
// Port-level checks for the probe packet checker and the bind that attaches them.
// Depends on ppc_pkg and probe_packet_checker_core.
module ppc_checker #(
  parameter int unsigned SEQ_SPACE = 65536
) (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] sequence_number,
  input logic [11:0] byte_count
);
  import ppc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(sequence_number))
    else $error("result word changed while stalled");

  a_size_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == ST_BAD_SIZE) ==
                   (byte_count < MIN_BYTES || byte_count > MAX_BYTES)))
    else $error("bad-size status disagrees with byte count");

  a_seq_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK || status == ST_DUPLICATE || status == ST_PAYLOAD)
    |-> {1'b0, sequence_number} < 33'(SEQ_SPACE))
    else $error("sequence beyond map passed range check");

  a_clear_blocks: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready during seen-map clear");

endmodule

bind probe_packet_checker_core ppc_checker #(
  .SEQ_SPACE(SEQ_SPACE)
) u_ppc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .sequence_number(sequence_number),
  .byte_count     (byte_count)
);
